FILE: hdl/xbr_pkg.sv
// Shared constants and types of the XMODEM block receiver.
`default_nettype none

package xbr_pkg;

   localparam int unsigned PAYLOAD_BYTES = 128;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned INDEX_W = 7;

   localparam logic [COUNT_W-1:0] NUMBER_POS = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] COMPLEMENT_POS = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] CHECKSUM_POS = COUNT_W'(PAYLOAD_BYTES + 2);

   localparam logic [7:0] SOH_CODE = 8'h01;
   localparam logic [7:0] EOT_CODE = 8'h04;
   localparam logic [7:0] CAN_CODE = 8'h18;
   localparam logic [8:0] COMPLEMENT_SUM = 9'h0ff;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_OK        = 3'd1,
      ST_DUP       = 3'd2,
      ST_RETRY     = 3'd3,
      ST_FINISHED  = 3'd4,
      ST_CANCELLED = 3'd5,
      ST_FAILED    = 3'd6
   } status_type;

   typedef struct packed {
      status_type         status;
      logic               data_valid;
      logic [7:0]         data_byte;
      logic [INDEX_W-1:0] data_index;
      logic               send_ack;
      logic [7:0]         block_number;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/xmodem_block_receiver.sv
// Top level of the XMODEM checksum block receiver with its stream registers.
`default_nettype none

// Takes one received byte or timeout event per item and returns exactly one
// result item for each. An item is held in an input register, and once the
// result register is free or being emptied, the verdict logic writes its result
// into the result register. A new item can be accepted every cycle as long as
// results are taken. When a result waits, at most one more item can be held in
// the input register. The configuration write loads the last accepted block
// number. It is held off while an item waits in the input register, and it
// should only be issued while no items are in flight.
module xmodem_block_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // rx_byte[7:0]
   input  wire logic        req_tuser,  // func[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0], data_byte[10:3], data_index[17:11], send_ack[18],
   // block_number[26:19], zero fill [31:27]
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tuser,  // data_valid[0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   logic                 in_valid_ff;
   logic                 in_func_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   xbr_pkg::result_type  out_ff;
   xbr_pkg::result_type  step_result;
   logic                 advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready = !in_valid_ff;

   xbr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .func     (in_func_ff),
      .rx_byte  (in_byte_ff),
      .cfg_we   (csr_valid && csr_ready),
      .cfg_data (csr_data),
      .result   (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_tready && req_tvalid) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_ff.data_valid;
   assign rsp_tdata = {5'd0, out_ff.block_number, out_ff.send_ack, out_ff.data_index,
                       out_ff.data_byte, out_ff.status};

endmodule

`default_nettype wire

FILE: hdl/xbr_core.sv
// Protocol state of the receiver and the per-item verdict logic.
`default_nettype none

module xbr_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic                func,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                cfg_we,
   input  wire logic [7:0]          cfg_data,
   output xbr_pkg::result_type      result
);

   logic                        in_block_ff, in_block_in;
   logic [xbr_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]                  running_sum_ff, running_sum_in;
   logic [7:0]                  got_number_ff, got_number_in;
   logic [7:0]                  got_complement_ff, got_complement_in;
   logic [7:0]                  last_number_ff, last_number_in;
   logic [xbr_pkg::COUNT_W-1:0] payload_pos;

   assign payload_pos = byte_count_ff - xbr_pkg::COUNT_W'(2);

   always_comb begin
      result = '0;
      result.status = xbr_pkg::ST_BUSY;
      in_block_in = in_block_ff;
      byte_count_in = byte_count_ff;
      running_sum_in = running_sum_ff;
      got_number_in = got_number_ff;
      got_complement_in = got_complement_ff;
      last_number_in = last_number_ff;
      if (!in_block_ff) begin
         priority if (func == xbr_pkg::FUNC_TIMEOUT) begin
            result.status = xbr_pkg::ST_RETRY;
         end else if (rx_byte == xbr_pkg::SOH_CODE) begin
            in_block_in = 1'b1;
            byte_count_in = '0;
            running_sum_in = '0;
         end else if (rx_byte == xbr_pkg::EOT_CODE) begin
            result.status = xbr_pkg::ST_FINISHED;
            result.send_ack = 1'b1;
         end else if (rx_byte == xbr_pkg::CAN_CODE) begin
            result.status = xbr_pkg::ST_CANCELLED;
         end else begin
            result.status = xbr_pkg::ST_RETRY;
         end
      end else if (func == xbr_pkg::FUNC_TIMEOUT) begin
         result.status = xbr_pkg::ST_FAILED;
         in_block_in = 1'b0;
         byte_count_in = '0;
      end else begin
         byte_count_in = byte_count_ff + xbr_pkg::COUNT_W'(1);
         priority if (byte_count_ff == xbr_pkg::NUMBER_POS) begin
            got_number_in = rx_byte;
         end else if (byte_count_ff == xbr_pkg::COMPLEMENT_POS) begin
            got_complement_in = rx_byte;
         end else if (byte_count_ff < xbr_pkg::CHECKSUM_POS) begin
            running_sum_in = running_sum_ff + rx_byte;
            result.data_valid = 1'b1;
            result.data_byte = rx_byte;
            result.data_index = payload_pos[xbr_pkg::INDEX_W-1:0];
         end else begin
            in_block_in = 1'b0;
            byte_count_in = '0;
            priority if ({1'b0, got_number_ff} + {1'b0, got_complement_ff}
                         != xbr_pkg::COMPLEMENT_SUM) begin
               result.status = xbr_pkg::ST_RETRY;
            end else if (got_number_ff == last_number_ff) begin
               result.status = xbr_pkg::ST_DUP;
            end else if (last_number_ff + 8'd1 != got_number_ff) begin
               result.status = xbr_pkg::ST_RETRY;
            end else if (running_sum_ff != rx_byte) begin
               result.status = xbr_pkg::ST_RETRY;
            end else begin
               result.status = xbr_pkg::ST_OK;
               result.block_number = got_number_ff;
               last_number_in = got_number_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff <= 1'b0;
         byte_count_ff <= '0;
         running_sum_ff <= '0;
         got_number_ff <= '0;
         got_complement_ff <= '0;
         last_number_ff <= '0;
      end else if (cfg_we) begin
         last_number_ff <= cfg_data;
      end else if (step_en) begin
         in_block_ff <= in_block_in;
         byte_count_ff <= byte_count_in;
         running_sum_ff <= running_sum_in;
         got_number_ff <= got_number_in;
         got_complement_ff <= got_complement_in;
         last_number_ff <= last_number_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= xbr_pkg::CHECKSUM_POS)
      else $error("Byte count ran past the checksum position.");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !in_block_ff |-> byte_count_ff == '0)
      else $error("Byte count is not cleared while waiting for a header.");

   a_ok_updates: assert property (@(posedge clock) disable iff (reset)
      step_en && !cfg_we && result.status == xbr_pkg::ST_OK
      |=> last_number_ff == $past(got_number_ff) && !in_block_ff)
      else $error("An accepted block did not update the last block number.");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      result.data_valid |-> result.status == xbr_pkg::ST_BUSY && in_block_ff)
      else $error("A payload byte came with a verdict or outside a block.");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench of the XMODEM checksum block receiver.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import xbr_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SEQ_PLAN_LEN = 9;
   localparam int FULL_BLOCK_BYTES = PAYLOAD_BYTES + 3;

   typedef enum {
      SEQ_GOOD,
      SEQ_DUP,
      SEQ_BAD_COMPLEMENT,
      SEQ_SKIP,
      SEQ_BAD_SUM,
      SEQ_CUT,
      SEQ_NOISE
   } seq_kind_type;

   typedef struct packed {
      logic       func;
      logic [7:0] rx;
      logic       fixed;
      status_type status;
   } directed_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tuser = FUNC_BYTE;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic       rsp_tuser;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // The expected value of a directed row travels beside the item it belongs to.
   logic       row_fixed = 1'b0;
   result_type row_fixed_result = '0;

   logic       blk_open = 1'b0;
   logic [7:0] blk_count = 8'h00;
   logic [7:0] blk_sum = 8'h00;
   logic [7:0] blk_number = 8'h00;
   logic [7:0] blk_complement = 8'h00;
   logic [7:0] blk_last = 8'h00;

   result_type receiver_outputs_due[$];
   logic [7:0] link_last = 8'h00;
   int         send_idle_pct = 7;
   int         recv_idle_pct = 81;
   int         items_sent = 0;
   int         results_checked = 0;
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         plan_pos = 0;
   int         status_seen [0:7] = '{default: 0};

   directed_row_type directed_rows [0:16] = '{
      '{FUNC_TIMEOUT, 8'h00,    1'b1, ST_RETRY},
      '{FUNC_BYTE,    8'h00,    1'b1, ST_RETRY},
      '{FUNC_BYTE,    8'hff,    1'b1, ST_RETRY},
      '{FUNC_BYTE,    EOT_CODE, 1'b1, ST_FINISHED},
      '{FUNC_BYTE,    CAN_CODE, 1'b1, ST_CANCELLED},
      '{FUNC_BYTE,    SOH_CODE, 1'b1, ST_BUSY},
      '{FUNC_TIMEOUT, 8'hff,    1'b1, ST_FAILED},
      '{FUNC_BYTE,    SOH_CODE, 1'b1, ST_BUSY},
      '{FUNC_BYTE,    EOT_CODE, 1'b0, ST_BUSY},
      '{FUNC_BYTE,    CAN_CODE, 1'b0, ST_BUSY},
      '{FUNC_BYTE,    SOH_CODE, 1'b0, ST_BUSY},
      '{FUNC_BYTE,    8'hff,    1'b0, ST_BUSY},
      '{FUNC_BYTE,    8'h00,    1'b0, ST_BUSY},
      '{FUNC_BYTE,    EOT_CODE, 1'b0, ST_BUSY},
      '{FUNC_TIMEOUT, 8'h00,    1'b1, ST_FAILED},
      '{FUNC_TIMEOUT, 8'h5a,    1'b1, ST_RETRY},
      '{FUNC_BYTE,    CAN_CODE, 1'b1, ST_CANCELLED}
   };

   seq_kind_type seq_plan [0:SEQ_PLAN_LEN-1] = '{
      SEQ_GOOD, SEQ_DUP, SEQ_CUT, SEQ_BAD_COMPLEMENT, SEQ_NOISE,
      SEQ_SKIP, SEQ_BAD_SUM, SEQ_GOOD, SEQ_CUT
   };

   xmodem_block_receiver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic advance_receiver(input logic func, input logic [7:0] rx,
                                   output result_type res);
      logic [7:0] next_number;
      res = '0;
      res.status = ST_BUSY;
      next_number = blk_last + 8'd1;
      if (!blk_open) begin
         if (func == FUNC_TIMEOUT) begin
            res.status = ST_RETRY;
         end else if (rx == SOH_CODE) begin
            blk_open = 1'b1;
            blk_count = 8'h00;
            blk_sum = 8'h00;
         end else if (rx == EOT_CODE) begin
            res.status = ST_FINISHED;
            res.send_ack = 1'b1;
         end else if (rx == CAN_CODE) begin
            res.status = ST_CANCELLED;
         end else begin
            res.status = ST_RETRY;
         end
      end else if (func == FUNC_TIMEOUT) begin
         res.status = ST_FAILED;
         blk_open = 1'b0;
      end else begin
         if (blk_count == NUMBER_POS) begin
            blk_number = rx;
         end else if (blk_count == COMPLEMENT_POS) begin
            blk_complement = rx;
         end else if (blk_count < CHECKSUM_POS) begin
            blk_sum = blk_sum + rx;
            res.data_valid = 1'b1;
            res.data_byte = rx;
            res.data_index = INDEX_W'(blk_count - 8'd2);
         end else begin
            blk_open = 1'b0;
            if ({1'b0, blk_number} + {1'b0, blk_complement} != COMPLEMENT_SUM) begin
               res.status = ST_RETRY;
            end else if (blk_number == blk_last) begin
               res.status = ST_DUP;
            end else if (blk_number != next_number) begin
               res.status = ST_RETRY;
            end else if (blk_sum != rx) begin
               res.status = ST_RETRY;
            end else begin
               res.status = ST_OK;
               res.block_number = blk_number;
               blk_last = blk_number;
            end
         end
         blk_count = blk_open ? blk_count + 8'd1 : 8'h00;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("Result %0d: %s is %0h, expected %0h.", results_checked, what, got, want);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type predicted;
      result_type got;
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            blk_last = csr_data;
         end
         if (req_tvalid && req_tready) begin
            advance_receiver(req_tuser, req_tdata, predicted);
            receiver_outputs_due.push_back(row_fixed ? row_fixed_result : predicted);
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got.status = status_type'(rsp_tdata[2:0]);
            got.data_valid = rsp_tuser;
            got.data_byte = rsp_tdata[10:3];
            got.data_index = rsp_tdata[17:11];
            got.send_ack = rsp_tdata[18];
            got.block_number = rsp_tdata[26:19];
            if (receiver_outputs_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 32'h0);
            end else begin
               want = receiver_outputs_due.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.data_valid !== want.data_valid)
                  report_mismatch("data_valid", got.data_valid, want.data_valid);
               if (got.data_byte !== want.data_byte)
                  report_mismatch("data_byte", got.data_byte, want.data_byte);
               if (got.data_index !== want.data_index)
                  report_mismatch("data_index", got.data_index, want.data_index);
               if (got.send_ack !== want.send_ack)
                  report_mismatch("send_ack", got.send_ack, want.send_ack);
               if (got.block_number !== want.block_number)
                  report_mismatch("block_number", got.block_number, want.block_number);
               status_seen[want.status]++;
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic func, input logic [7:0] rx, input logic fixed,
                            input result_type fixed_result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= rx;
      row_fixed <= fixed;
      row_fixed_result <= fixed_result;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (receiver_outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_last_block(input logic [7:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      link_last = value;
   endtask

   task automatic send_sequence(input seq_kind_type kind);
      logic [7:0] number;
      logic [7:0] complement;
      logic [7:0] sum;
      logic [7:0] data;
      int cut_at;
      int n;
      if (kind == SEQ_NOISE) begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            case ($urandom_range(3))
               0: data = SOH_CODE;
               1: data = EOT_CODE;
               2: data = CAN_CODE;
               default: data = 8'($urandom);
            endcase
            send_item(FUNC_BYTE, data, 1'b0, '0);
         end
         send_item(FUNC_TIMEOUT, 8'($urandom), 1'b0, '0);
      end else begin
         number = link_last + 8'd1;
         case (kind)
            SEQ_DUP: number = link_last;
            SEQ_SKIP: number = link_last + 8'($urandom_range(2, 255));
            SEQ_BAD_COMPLEMENT, SEQ_CUT: number = 8'($urandom);
            default: ;
         endcase
         complement = ~number;
         if (kind == SEQ_BAD_COMPLEMENT) complement = complement ^ 8'($urandom_range(1, 255));
         cut_at = (kind == SEQ_CUT) ? $urandom_range(0, FULL_BLOCK_BYTES - 1)
                                    : FULL_BLOCK_BYTES;
         sum = 8'h00;
         send_item(FUNC_BYTE, SOH_CODE, 1'b0, '0);
         for (int pos = 0; pos < cut_at; pos++) begin
            if (pos == 0) begin
               data = number;
            end else if (pos == 1) begin
               data = complement;
            end else if (pos < FULL_BLOCK_BYTES - 1) begin
               data = 8'($urandom);
               sum = sum + data;
            end else if (kind == SEQ_BAD_SUM) begin
               data = sum + 8'($urandom_range(1, 255));
            end else begin
               data = sum;
            end
            send_item(FUNC_BYTE, data, 1'b0, '0);
         end
         if (kind == SEQ_CUT) send_item(FUNC_TIMEOUT, 8'($urandom), 1'b0, '0);
         if (kind == SEQ_GOOD) link_last = number;
      end
   endtask

   task automatic run_phase(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         send_sequence(seq_plan[plan_pos % SEQ_PLAN_LEN]);
         plan_pos++;
         if (plan_pos % 4 == 0) drain_results();
      end
   endtask

   initial begin : stimulus
      result_type fixed_result;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         fixed_result = '0;
         fixed_result.status = directed_rows[i].status;
         fixed_result.send_ack = (directed_rows[i].status == ST_FINISHED);
         send_item(directed_rows[i].func, directed_rows[i].rx, directed_rows[i].fixed,
                   fixed_result);
      end

      write_last_block(8'hff);
      run_phase(250);

      send_idle_pct = 81;
      recv_idle_pct = 7;
      write_last_block(8'h00);
      run_phase(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_last_block(8'($urandom));
      run_phase(250);

      drain_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d items and checked %0d results under three idling patterns.",
               items_sent, results_checked);
      $display("Verdicts: %0d ok, %0d duplicate, %0d retry, %0d failed, %0d finished, %0d %s",
               status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_RETRY],
               status_seen[ST_FAILED], status_seen[ST_FINISHED], status_seen[ST_CANCELLED],
               "cancelled.");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
